/* src/fdg_pkg.sv */
package fdg_pkg;

  // grid geometry
  localparam int CELLS = 256;
  localparam int CW    = $clog2(CELLS);

  // field, source/coefficient and accumulator widths
  localparam int FW    = 21;
  localparam int SW    = 17;
  localparam int GW    = 18;
  localparam int DW    = FW + 1;
  localparam int WW    = 44;
  localparam int CMP_W = ((CW > 9) ? CW : 9) + 1;

  localparam logic [SW-1:0] ONE = SW'(65536);

  // request modes
  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_DIEL  = 3'd0;
  localparam logic [2:0] CFG_LOSS  = 3'd1;
  localparam logic [2:0] CFG_SRC   = 3'd2;
  localparam logic [2:0] CFG_DECAY = 3'd3;
  localparam logic [2:0] CFG_GAIN  = 3'd4;
  localparam logic [2:0] CFG_SCALE = 3'd5;

  typedef logic signed [FW-1:0] fld_t;
  typedef logic [CW-1:0]        idx_t;

  // which store a pipeline slot updates
  localparam logic SEL_H = 1'b0;
  localparam logic SEL_E = 1'b1;

  typedef struct packed {
    logic sel;
    idx_t addr;
  } tag_t;

  typedef struct packed {
    logic                  v;
    fld_t                  old;
    logic signed [DW-1:0]  diff;
    logic [SW-1:0]         s;
    logic [GW-1:0]         c;
    tag_t                  tag;
  } mac_req_t;

  typedef struct packed {
    logic v;
    fld_t val;
    tag_t tag;
  } mac_rsp_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    fld_t data;
  } wr_t;

  // clamp a wide signed value to the field range
  function automatic fld_t sat_wide(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = WW'(1048575);
    lo = -WW'(1048576);
    if (x > hi) begin
      return FW'(hi);
    end else if (x < lo) begin
      return FW'(lo);
    end
    return FW'(x);
  endfunction

endpackage

/* src/fdg_grid.sv */
module fdg_grid (
  input  logic              clk,
  input  fdg_pkg::wr_t      e_wr,
  input  fdg_pkg::idx_t     e_raddr,
  output fdg_pkg::fld_t     e_rdata,
  input  fdg_pkg::wr_t      h_wr,
  input  fdg_pkg::idx_t     h_raddr,
  output fdg_pkg::fld_t     h_rdata
);

  fdg_pkg::fld_t e_mem [fdg_pkg::CELLS];
  fdg_pkg::fld_t h_mem [fdg_pkg::CELLS];
  fdg_pkg::fld_t e_rd_r;
  fdg_pkg::fld_t h_rd_r;

  // electric store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (e_wr.we) begin
      e_mem[e_wr.addr] <= e_wr.data;
    end
    e_rd_r <= e_mem[e_raddr];
  end

  // magnetic store
  always_ff @(posedge clk) begin
    if (h_wr.we) begin
      h_mem[h_wr.addr] <= h_wr.data;
    end
    h_rd_r <= h_mem[h_raddr];
  end

  assign e_rdata = e_rd_r;
  assign h_rdata = h_rd_r;

endmodule

/* src/fdg_mac.sv */
module fdg_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  fdg_pkg::mac_req_t req,
  output fdg_pkg::mac_rsp_t rsp,
  output logic              pend
);

  localparam int P1W = fdg_pkg::SW + 1 + fdg_pkg::FW;
  localparam int P2W = fdg_pkg::GW + 1 + fdg_pkg::DW;

  // stage 1: operand capture
  logic                          s1_v_r;
  fdg_pkg::fld_t                 s1_old_r;
  logic signed [fdg_pkg::DW-1:0] s1_diff_r;
  logic [fdg_pkg::SW-1:0]        s1_s_r;
  logic [fdg_pkg::GW-1:0]        s1_c_r;
  fdg_pkg::tag_t                 s1_tag_r;

  // stage 2: products
  logic                          s2_v_r;
  logic signed [P1W-1:0]         p1_r;
  logic signed [P2W-1:0]         p2_r;
  logic signed [P1W-1:0]         p1_nxt;
  logic signed [P2W-1:0]         p2_nxt;
  fdg_pkg::tag_t                 s2_tag_r;

  // stage 3: rounded, clamped result
  logic                          s3_v_r;
  fdg_pkg::fld_t                 val_r;
  fdg_pkg::fld_t                 val_nxt;
  fdg_pkg::tag_t                 s3_tag_r;
  logic signed [fdg_pkg::WW-1:0] acc;

  // multiply both terms, then sum, round half up and clamp
  always_comb begin
    p1_nxt  = $signed({1'b0, s1_s_r}) * s1_old_r;
    p2_nxt  = $signed({1'b0, s1_c_r}) * s1_diff_r;
    acc     = fdg_pkg::WW'(p1_r) + fdg_pkg::WW'(p2_r) + fdg_pkg::WW'(32768);
    val_nxt = fdg_pkg::sat_wide(acc >>> 16);
  end

  // advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= req.v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    s1_old_r  <= req.old;
    s1_diff_r <= req.diff;
    s1_s_r    <= req.s;
    s1_c_r    <= req.c;
    s1_tag_r  <= req.tag;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    s2_tag_r  <= s1_tag_r;
    val_r     <= val_nxt;
    s3_tag_r  <= s2_tag_r;
  end

  assign rsp.v   = s3_v_r;
  assign rsp.val = val_r;
  assign rsp.tag = s3_tag_r;
  assign pend    = s1_v_r | s2_v_r | s3_v_r;

endmodule

/* src/fdtd_1d_lossy_grid_step.sv */
// One-dimensional lossy FDTD grid of CELLS electric and CELLS magnetic cells
// (magnetic stored times 377). A request is taken when start is high and busy
// is low. Mode 0 runs one time step: a magnetic sweep then an electric sweep,
// each streaming one cell per cycle through a single shared multiply-add
// pipeline fed by one read port on each field memory; each sweep is followed
// by a drain of the read stage and the unit, and the step ends with the cell
// read and the result register. Mode 1 only reads a cell and returns its
// result through the same read and result register. Each request yields
// exactly one result, shown for a single cycle with out_strobe high; the
// receiver cannot stall it, so it must take it in that cycle. After reset the
// block clears both memories, one cell per cycle, with busy high;
// configuration writes are taken at any time but must only be issued while
// busy is low.
module fdtd_1d_lossy_grid_step (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [7:0]              in_cell_req,
  input  logic [16:0]             in_source_h,
  input  logic [16:0]             in_source_e,
  output logic                    out_strobe,
  output logic signed [20:0]      out_electric_value,
  output logic signed [20:0]      out_magnetic_value,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [16:0]             cfg_wdata
);

  localparam int CW    = fdg_pkg::CW;
  localparam int SW    = fdg_pkg::SW;
  localparam int GW    = fdg_pkg::GW;
  localparam int DW    = fdg_pkg::DW;
  localparam int WW    = fdg_pkg::WW;
  localparam int CMP_W = fdg_pkg::CMP_W;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HSWP  = 3'd2;
  localparam logic [2:0] ST_HDRN  = 3'd3;
  localparam logic [2:0] ST_ESWP  = 3'd4;
  localparam logic [2:0] ST_EDRN  = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_RESP  = 3'd7;

  localparam fdg_pkg::idx_t LAST = CW'(fdg_pkg::CELLS - 1);

  // configuration
  logic [8:0]    diel_r;
  logic [8:0]    loss_r;
  logic [7:0]    src_r;
  logic [SW-1:0] decay_r;
  logic [SW-1:0] gain_r;
  logic [SW-1:0] scale_r;
  logic [33:0]   lc_prod_r;
  logic [GW-1:0] lossy_c_r;

  // sequencer
  logic [2:0]    state_r, state_nxt;
  fdg_pkg::idx_t cnt_r, cnt_nxt;
  logic          accept;
  logic [7:0]    req_r;
  logic [SW-1:0] srch_r;
  logic [SW-1:0] srce_r;
  logic          pipe_busy;
  logic          mac_pend;

  // read stage
  logic          iss_v;
  logic          iss_sel;
  logic          b_v_r;
  logic          b_sel_r;
  fdg_pkg::idx_t b_j_r;
  fdg_pkg::fld_t prev_r;
  fdg_pkg::fld_t e1_r;

  // memory and unit connections
  fdg_pkg::wr_t     e_wr, h_wr;
  fdg_pkg::idx_t    e_raddr, h_raddr;
  fdg_pkg::fld_t    e_rd, h_rd;
  fdg_pkg::mac_req_t mreq;
  fdg_pkg::mac_rsp_t rsp;

  // write-back
  fdg_pkg::idx_t    tgt;
  logic [CMP_W-1:0] tgt_ext;
  logic [CMP_W-1:0] wa_ext;
  logic [CMP_W-1:0] src_ext;
  logic             h_hit, e_hit;
  logic signed [WW-1:0] rsp_w, e1_w, srch_w, srce_w;
  fdg_pkg::fld_t    h_val, e_val, e0_val;

  // result
  logic          req_ok;
  fdg_pkg::idx_t req_idx;
  logic          out_strobe_r;
  fdg_pkg::fld_t out_e_r, out_h_r;

  fdg_grid u_grid (
    .clk     (clk),
    .e_wr    (e_wr),
    .e_raddr (e_raddr),
    .e_rdata (e_rd),
    .h_wr    (h_wr),
    .h_raddr (h_raddr),
    .h_rdata (h_rd)
  );

  fdg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (rsp),
    .pend  (mac_pend)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign pipe_busy = b_v_r | mac_pend;
  assign req_idx   = CW'(req_r);
  assign req_ok    = CMP_W'(req_r) < CMP_W'(fdg_pkg::CELLS);

  // write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diel_r  <= 9'd100;
      loss_r  <= 9'd180;
      src_r   <= 8'd50;
      decay_r <= SW'(62967);
      gain_r  <= SW'(64251);
      scale_r <= SW'(7282);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdg_pkg::CFG_DIEL:  diel_r  <= cfg_wdata[8:0];
        fdg_pkg::CFG_LOSS:  loss_r  <= cfg_wdata[8:0];
        fdg_pkg::CFG_SRC:   src_r   <= cfg_wdata[7:0];
        fdg_pkg::CFG_DECAY: decay_r <= cfg_wdata;
        fdg_pkg::CFG_GAIN:  gain_r  <= cfg_wdata;
        fdg_pkg::CFG_SCALE: scale_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // derive the lossy dielectric coupling, rounded to Q2.16
  always_ff @(posedge clk) begin
    lc_prod_r <= scale_r * gain_r;
    lossy_c_r <= GW'((lc_prod_r + 34'd32768) >> 16);
  end

  // sequence clear, sweeps, drains and read
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = (in_mode == fdg_pkg::MODE_STEP) ? ST_HSWP : ST_READ;
        end
      end
      ST_HSWP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_HDRN;
          cnt_nxt   = '0;
        end
      end
      ST_HDRN: begin
        if (!pipe_busy) begin
          state_nxt = ST_ESWP;
        end
      end
      ST_ESWP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_EDRN;
          cnt_nxt   = '0;
        end
      end
      ST_EDRN: begin
        if (!pipe_busy) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_cell_req;
      srch_r <= in_source_h;
      srce_r <= in_source_e;
    end
  end

  // issue reads: the magnetic sweep reads E at j and H at j-1
  always_comb begin
    iss_v   = (state_r == ST_HSWP) || (state_r == ST_ESWP);
    iss_sel = (state_r == ST_ESWP) ? fdg_pkg::SEL_E : fdg_pkg::SEL_H;
    e_raddr = cnt_r;
    h_raddr = cnt_r;
    if (state_r == ST_HSWP) begin
      h_raddr = cnt_r - 1'b1;
    end else if (state_r == ST_READ) begin
      e_raddr = req_idx;
      h_raddr = req_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= iss_v;
    end
  end

  // track the previous neighbor and the old E[1] for the boundary
  always_ff @(posedge clk) begin
    b_sel_r <= iss_sel;
    b_j_r   <= cnt_r;
    if (b_v_r) begin
      prev_r <= (b_sel_r == fdg_pkg::SEL_E) ? h_rd : e_rd;
    end
    if (b_v_r && (b_sel_r == fdg_pkg::SEL_E) && (b_j_r == CW'(1))) begin
      e1_r <= e_rd;
    end
  end

  // select operands and coefficients for the shared unit
  always_comb begin
    tgt      = (b_sel_r == fdg_pkg::SEL_E) ? b_j_r : b_j_r - 1'b1;
    tgt_ext  = CMP_W'(tgt);
    mreq.v   = b_v_r && (b_j_r != '0);
    mreq.tag.sel  = b_sel_r;
    mreq.tag.addr = tgt;
    if (b_sel_r == fdg_pkg::SEL_H) begin
      mreq.old  = h_rd;
      mreq.diff = DW'(e_rd) - DW'(prev_r);
      if (tgt_ext < CMP_W'(loss_r)) begin
        mreq.s = fdg_pkg::ONE;
        mreq.c = GW'(fdg_pkg::ONE);
      end else begin
        mreq.s = decay_r;
        mreq.c = GW'(gain_r);
      end
    end else begin
      mreq.old  = e_rd;
      mreq.diff = DW'(h_rd) - DW'(prev_r);
      if (tgt_ext < CMP_W'(diel_r)) begin
        mreq.s = fdg_pkg::ONE;
        mreq.c = GW'(fdg_pkg::ONE);
      end else if (tgt_ext < CMP_W'(loss_r)) begin
        mreq.s = fdg_pkg::ONE;
        mreq.c = GW'(scale_r);
      end else begin
        mreq.s = decay_r;
        mreq.c = lossy_c_r;
      end
    end
  end

  // apply source corrections on write-back
  always_comb begin
    wa_ext  = CMP_W'(rsp.tag.addr);
    src_ext = CMP_W'(src_r);
    h_hit   = (src_r != '0) && (wa_ext == src_ext - CMP_W'(1));
    e_hit   = (wa_ext == src_ext);
    rsp_w   = WW'(rsp.val);
    e1_w    = WW'(e1_r);
    srch_w  = $signed(WW'(srch_r));
    srce_w  = $signed(WW'(srce_r));
    h_val   = h_hit ? fdg_pkg::sat_wide(rsp_w - srch_w) : rsp.val;
    e_val   = e_hit ? fdg_pkg::sat_wide(rsp_w + srce_w) : rsp.val;
    e0_val  = (src_r == '0) ? fdg_pkg::sat_wide(e1_w + srce_w) : e1_r;
  end

  // drive memory writes: clear pass, unit results, boundary copy
  always_comb begin
    e_wr.we   = 1'b0;
    e_wr.addr = rsp.tag.addr;
    e_wr.data = e_val;
    h_wr.we   = 1'b0;
    h_wr.addr = rsp.tag.addr;
    h_wr.data = h_val;
    if (state_r == ST_CLEAR) begin
      e_wr.we   = 1'b1;
      e_wr.addr = cnt_r;
      e_wr.data = '0;
      h_wr.we   = 1'b1;
      h_wr.addr = cnt_r;
      h_wr.data = '0;
    end else begin
      if (rsp.v && (rsp.tag.sel == fdg_pkg::SEL_E)) begin
        e_wr.we = 1'b1;
      end else if ((state_r == ST_EDRN) && !pipe_busy) begin
        e_wr.we   = 1'b1;
        e_wr.addr = '0;
        e_wr.data = e0_val;
      end
      if (rsp.v && (rsp.tag.sel == fdg_pkg::SEL_H)) begin
        h_wr.we = 1'b1;
      end
    end
  end

  // register the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_RESP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP) begin
      out_e_r <= req_ok ? e_rd : '0;
      out_h_r <= req_ok ? h_rd : '0;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_electric_value = out_e_r;
  assign out_magnetic_value = out_h_r;

  // pipeline is empty whenever a request can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !pipe_busy)
    else $error("update pipeline busy while idle");

  // a result follows only the response state
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_RESP))
    else $error("result strobe without read");

  // magnetic write-backs finish before the electric sweep
  a_h_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.v && (rsp.tag.sel == fdg_pkg::SEL_H)) |->
      (state_r == ST_HSWP || state_r == ST_HDRN))
    else $error("magnetic update outside its sweep");

  // electric write-backs stay inside the electric sweep
  a_e_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.v && (rsp.tag.sel == fdg_pkg::SEL_E)) |->
      (state_r == ST_ESWP || state_r == ST_EDRN))
    else $error("electric update outside its sweep");

endmodule

/* dv/fdtd_1d_lossy_grid_step_tb.sv */
module fdtd_1d_lossy_grid_step_tb;

  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_REQS = 120;

  typedef struct {
    fdg_pkg::fld_t elec;
    fdg_pkg::fld_t mag;
  } cell_probe_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_mode;
  logic [7:0] in_cell_req;
  logic [16:0] in_source_h;
  logic [16:0] in_source_e;
  logic out_strobe;
  logic signed [20:0] out_electric_value;
  logic signed [20:0] out_magnetic_value;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [16:0] cfg_wdata;

  // shadow copy of the grid and its settings
  fdg_pkg::fld_t elec_grid [fdg_pkg::CELLS];
  fdg_pkg::fld_t mag_grid [fdg_pkg::CELLS];
  logic [8:0] diel_first;
  logic [8:0] lossy_first;
  logic [7:0] feed_cell;
  logic [16:0] decay_coef;
  logic [16:0] gain_coef;
  logic [16:0] diel_coef;

  cell_probe_t pending_probes[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  bit idle_enable = 1'b1;

  fdtd_1d_lossy_grid_step DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_cell_req(in_cell_req),
    .in_source_h(in_source_h),
    .in_source_e(in_source_e),
    .out_strobe(out_strobe),
    .out_electric_value(out_electric_value),
    .out_magnetic_value(out_magnetic_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // clamp to the signed 21-bit field range
  function automatic fdg_pkg::fld_t clamp_field(input longint x);
    if (x > 1048575) begin
      return fdg_pkg::FW'(1048575);
    end else if (x < -1048576) begin
      return fdg_pkg::FW'(-1048576);
    end
    return fdg_pkg::FW'(x);
  endfunction

  // one cell: (self * prior + couple * diff) / 2^16, rounded half up, clamped
  function automatic fdg_pkg::fld_t yee_cell(input fdg_pkg::fld_t prior, input longint diff,
                                             input longint self_k, input longint couple_k);
    return clamp_field((self_k * longint'(prior) + couple_k * diff + 32768) >>> 16);
  endfunction

  // run one time step on the shadow grid
  function automatic void advance_grid(input logic [16:0] src_h, input logic [16:0] src_e);
    longint lossy_couple;
    longint diff;
    lossy_couple = (longint'(diel_coef) * longint'(gain_coef) + 32768) >>> 16;
    for (int m = 0; m < fdg_pkg::CELLS - 1; m++) begin
      diff = longint'(elec_grid[m + 1]) - longint'(elec_grid[m]);
      if (m < int'(lossy_first)) begin
        mag_grid[m] = yee_cell(mag_grid[m], diff, 65536, 65536);
      end else begin
        mag_grid[m] = yee_cell(mag_grid[m], diff, longint'(decay_coef), longint'(gain_coef));
      end
    end
    if (feed_cell != 8'd0) begin
      mag_grid[feed_cell - 1] = clamp_field(longint'(mag_grid[feed_cell - 1]) - longint'(src_h));
    end
    elec_grid[0] = elec_grid[1];
    for (int m = 1; m < fdg_pkg::CELLS; m++) begin
      diff = longint'(mag_grid[m]) - longint'(mag_grid[m - 1]);
      if (m < int'(diel_first)) begin
        elec_grid[m] = yee_cell(elec_grid[m], diff, 65536, 65536);
      end else if (m < int'(lossy_first)) begin
        elec_grid[m] = yee_cell(elec_grid[m], diff, 65536, longint'(diel_coef));
      end else begin
        elec_grid[m] = yee_cell(elec_grid[m], diff, longint'(decay_coef), lossy_couple);
      end
    end
    elec_grid[feed_cell] = clamp_field(longint'(elec_grid[feed_cell]) + longint'(src_e));
  endfunction

  // source value: mostly in range, sometimes the corners or any 17-bit value
  function automatic logic [16:0] pick_source();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom());
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // present one request and hold it until it is taken, then predict its result
  task automatic send_req(input logic mode, input logic [7:0] cell_idx,
                          input logic [16:0] src_h, input logic [16:0] src_e);
    int gap;
    cell_probe_t probe;
    gap = 0;
    while (idle_enable && $urandom_range(0, 99) < 22) gap++;
    // hold start low for the drawn gap once the block is ready again
    if (gap != 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_cell_req <= cell_idx;
    in_source_h <= src_h;
    in_source_e <= src_e;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mode == fdg_pkg::MODE_STEP) begin
      advance_grid(src_h, src_e);
    end
    probe.elec = elec_grid[cell_idx];
    probe.mag = mag_grid[cell_idx];
    pending_probes.push_back(probe);
  endtask

  // drop start and wait until every result is back and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_probes.size() != 0 || busy) @(posedge clk);
  endtask

  // write one register; the caller lowers cfg_we after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      fdg_pkg::CFG_DIEL: diel_first = data[8:0];
      fdg_pkg::CFG_LOSS: lossy_first = data[8:0];
      fdg_pkg::CFG_SRC: feed_cell = data[7:0];
      fdg_pkg::CFG_DECAY: decay_coef = data;
      fdg_pkg::CFG_GAIN: gain_coef = data;
      fdg_pkg::CFG_SCALE: diel_coef = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [8:0] ds, input logic [8:0] ls,
                             input logic [7:0] sc, input logic [16:0] ld,
                             input logic [16:0] lg, input logic [16:0] sf);
    wait_idle();
    write_reg(fdg_pkg::CFG_DIEL, 17'(ds));
    write_reg(fdg_pkg::CFG_LOSS, 17'(ls));
    write_reg(fdg_pkg::CFG_SRC, 17'(sc));
    write_reg(fdg_pkg::CFG_DECAY, ld);
    write_reg(fdg_pkg::CFG_GAIN, lg);
    write_reg(fdg_pkg::CFG_SCALE, sf);
    cfg_we <= 1'b0;
  endtask

  // empty grid reads, then steps with extreme sources under reset settings
  task automatic test_reset_state();
    send_req(fdg_pkg::MODE_READ, 8'd0, 17'd0, 17'd0);
    send_req(fdg_pkg::MODE_READ, 8'd255, 17'h1FFFF, 17'h1FFFF);
    send_req(fdg_pkg::MODE_STEP, 8'd50, 17'h1FFFF, 17'h1FFFF);
    send_req(fdg_pkg::MODE_STEP, 8'd49, 17'd65536, 17'd65536);
    send_req(fdg_pkg::MODE_STEP, 8'd51, 17'd0, 17'd0);
    send_req(fdg_pkg::MODE_READ, 8'd48, 17'd0, 17'd0);
  endtask

  // source at cell zero: skip the magnetic correction, add after the boundary copy
  task automatic test_source_at_cell_zero();
    load_config(9'd100, 9'd180, 8'd0, 17'd62967, 17'd64251, 17'd7282);
    send_req(fdg_pkg::MODE_STEP, 8'd0, 17'd65536, 17'd40000);
    send_req(fdg_pkg::MODE_STEP, 8'd1, 17'd30000, 17'd65536);
    send_req(fdg_pkg::MODE_READ, 8'd0, 17'd0, 17'd0);
  endtask

  // region bounds at and beyond the grid end
  task automatic test_empty_regions();
    load_config(9'd511, 9'd511, 8'd255, 17'd62967, 17'd64251, 17'd7282);
    send_req(fdg_pkg::MODE_STEP, 8'd255, 17'd65536, 17'd65536);
    send_req(fdg_pkg::MODE_STEP, 8'd254, 17'd12345, 17'd54321);
    load_config(9'd0, 9'd256, 8'd128, 17'd62967, 17'd64251, 17'd7282);
    send_req(fdg_pkg::MODE_STEP, 8'd128, 17'd65536, 17'd65536);
    send_req(fdg_pkg::MODE_STEP, 8'd127, 17'd0, 17'd65536);
    load_config(9'd256, 9'd0, 8'd1, 17'd62967, 17'd64251, 17'd7282);
    send_req(fdg_pkg::MODE_STEP, 8'd1, 17'd65536, 17'd65536);
  endtask

  // coefficients near 2.0 drive fields into saturation, zero ones flush them
  task automatic test_coefficient_saturation();
    load_config(9'd64, 9'd128, 8'd200, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    repeat (5) send_req(fdg_pkg::MODE_STEP, 8'd200, 17'h1FFFF, 17'h1FFFF);
    send_req(fdg_pkg::MODE_READ, 8'd255, 17'd0, 17'd0);
    load_config(9'd0, 9'd0, 8'd10, 17'd0, 17'd0, 17'd0);
    send_req(fdg_pkg::MODE_STEP, 8'd10, 17'd0, 17'd0);
    send_req(fdg_pkg::MODE_STEP, 8'd9, 17'd0, 17'd0);
  endtask

  // writes to indexes past the register file change nothing
  task automatic test_unused_register_index();
    load_config(9'd100, 9'd180, 8'd50, 17'd62967, 17'd64251, 17'd7282);
    @(posedge clk);
    write_reg(REG_UNUSED_LO, 17'h1FFFF);
    write_reg(REG_UNUSED_HI, 17'h1FFFF);
    cfg_we <= 1'b0;
    send_req(fdg_pkg::MODE_STEP, 8'd50, 17'd65536, 17'd65536);
    send_req(fdg_pkg::MODE_READ, 8'd49, 17'd0, 17'd0);
  endtask

  // random settings per phase, then a mix of steps and reads
  task automatic test_random_steps();
    logic [8:0] ds;
    logic [8:0] ls;
    logic [7:0] sc;
    logic [16:0] coef [3];
    logic mode;
    logic [7:0] cell_idx;
    for (int phase = 0; phase < 8; phase++) begin
      idle_enable = (phase != 3);
      ds = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 256));
      ls = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 256));
      sc = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      for (int k = 0; k < 3; k++) begin
        coef[k] = ($urandom_range(0, 5) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
      end
      load_config(ds, ls, sc, coef[0], coef[1], coef[2]);
      for (int n = 0; n < PHASE_REQS; n++) begin
        mode = ($urandom_range(0, 99) < 55) ? fdg_pkg::MODE_STEP : fdg_pkg::MODE_READ;
        if ($urandom_range(0, 3) == 0) begin
          cell_idx = sc + 8'($urandom_range(0, 2)) - 8'd1;
        end else begin
          cell_idx = 8'($urandom_range(0, 255));
        end
        send_req(mode, cell_idx, pick_source(), pick_source());
      end
    end
    idle_enable = 1'b1;
  endtask

  // compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    cell_probe_t want;
    if (rst_n && out_strobe) begin
      if (pending_probes.size() == 0) begin
        $display("%0t: result with none expected: electric %0d magnetic %0d",
                 $time, out_electric_value, out_magnetic_value);
        mismatch_count++;
      end else begin
        want = pending_probes.pop_front();
        if (out_electric_value !== want.elec) begin
          $display("%0t: electric_value expected %0d actual %0d",
                   $time, want.elec, out_electric_value);
          mismatch_count++;
        end
        if (out_magnetic_value !== want.mag) begin
          $display("%0t: magnetic_value expected %0d actual %0d",
                   $time, want.mag, out_magnetic_value);
          mismatch_count++;
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= fdg_pkg::MODE_READ;
    in_cell_req <= 8'd0;
    in_source_h <= 17'd0;
    in_source_e <= 17'd0;
    cfg_we <= 1'b0;
    cfg_index <= fdg_pkg::CFG_DIEL;
    cfg_wdata <= 17'd0;
    diel_first = 9'd100;
    lossy_first = 9'd180;
    feed_cell = 8'd50;
    decay_coef = 17'd62967;
    gain_coef = 17'd64251;
    diel_coef = 17'd7282;
    for (int m = 0; m < fdg_pkg::CELLS; m++) begin
      elec_grid[m] = '0;
      mag_grid[m] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_source_at_cell_zero();
    test_empty_regions();
    test_coefficient_saturation();
    test_unused_register_index();
    test_random_steps();

    // drain, then let the block settle
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_probes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
